>>> rtl/rct_pkg.sv
// Package for the reference count table: table sizes, command and status
// codes, and the packet and result types that travel along the cell chain.
// No dependencies.
`default_nettype none

package rct_pkg;

  // Table geometry and field widths.
  localparam int ENTRIES    = 16;
  localparam int ID_BITS    = 16;
  localparam int COUNT_BITS = 16;
  localparam int PTR_BITS   = 32;

  localparam logic [ID_BITS-1:0]    ID_MAX    = '1;
  localparam logic [ID_BITS-1:0]    ID_ONE    = ID_BITS'(1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // Command codes.
  localparam logic [1:0] CMD_REGISTER  = 2'd0;
  localparam logic [1:0] CMD_INCREMENT = 2'd1;
  localparam logic [1:0] CMD_DECREMENT = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  // One command on its way through the chain, with the result built so far.
  typedef struct packed {
    logic                  active;
    logic [1:0]            cmd;
    logic [PTR_BITS-1:0]   ptr;
    logic [ID_BITS-1:0]    eid;
    logic [ID_BITS-1:0]    nid;
    logic                  hit;
    logic [1:0]            status;
    logic [ID_BITS-1:0]    assigned;
    logic [COUNT_BITS-1:0] count;
    logic                  released;
    logic [PTR_BITS-1:0]   rel_ptr;
  } rct_pkt_t;

  // Finished result as it waits on the output side.
  typedef struct packed {
    logic [1:0]            status;
    logic [ID_BITS-1:0]    assigned;
    logic [COUNT_BITS-1:0] count;
    logic                  released;
    logic [PTR_BITS-1:0]   rel_ptr;
  } rct_res_t;

endpackage

`default_nettype wire

>>> rtl/rct_cell.sv
// One slot of the reference count table: holds an id, a pointer and a count,
// acts on a passing command packet and registers it for the next cell.
// Depends on rct_pkg.
`default_nettype none

module rct_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rct_pkg::rct_pkt_t pkt_in,
  output rct_pkg::rct_pkt_t      pkt_out
);

  logic                           valid;
  logic                           valid_next;
  logic [rct_pkg::ID_BITS-1:0]    slot_id;
  logic [rct_pkg::ID_BITS-1:0]    slot_id_next;
  logic [rct_pkg::PTR_BITS-1:0]   slot_ptr;
  logic [rct_pkg::PTR_BITS-1:0]   slot_ptr_next;
  logic [rct_pkg::COUNT_BITS-1:0] slot_cnt;
  logic [rct_pkg::COUNT_BITS-1:0] slot_cnt_next;
  logic [rct_pkg::COUNT_BITS-1:0] cnt_dec;
  rct_pkg::rct_pkt_t              pkt_next;
  logic                           match;

  assign match   = valid && (slot_id == pkt_in.eid);
  assign cnt_dec = (slot_cnt != '0) ? slot_cnt - rct_pkg::COUNT_ONE : '0;

  // The first cell that can serve a command claims it; later cells pass it on.
  always_comb begin
    pkt_next      = pkt_in;
    valid_next    = valid;
    slot_id_next  = slot_id;
    slot_ptr_next = slot_ptr;
    slot_cnt_next = slot_cnt;
    if (pkt_in.active && !pkt_in.hit) begin
      case (pkt_in.cmd)
        rct_pkg::CMD_REGISTER: begin
          if (!valid) begin
            valid_next        = 1'b1;
            slot_id_next      = pkt_in.nid;
            slot_ptr_next     = pkt_in.ptr;
            slot_cnt_next     = rct_pkg::COUNT_ONE;
            pkt_next.hit      = 1'b1;
            pkt_next.status   = rct_pkg::ST_OK;
            pkt_next.assigned = pkt_in.nid;
            pkt_next.count    = rct_pkg::COUNT_ONE;
          end
        end
        rct_pkg::CMD_INCREMENT: begin
          if (match) begin
            pkt_next.hit = 1'b1;
            if (slot_cnt == rct_pkg::COUNT_MAX) begin
              pkt_next.status = rct_pkg::ST_SATURATED;
              pkt_next.count  = slot_cnt;
            end else begin
              slot_cnt_next   = slot_cnt + rct_pkg::COUNT_ONE;
              pkt_next.status = rct_pkg::ST_OK;
              pkt_next.count  = slot_cnt + rct_pkg::COUNT_ONE;
            end
          end
        end
        rct_pkg::CMD_DECREMENT: begin
          if (match) begin
            pkt_next.hit    = 1'b1;
            pkt_next.status = rct_pkg::ST_OK;
            pkt_next.count  = cnt_dec;
            slot_cnt_next   = cnt_dec;
            // The last reference is gone: free the slot and hand back its pointer.
            if (cnt_dec == '0) begin
              pkt_next.released = 1'b1;
              pkt_next.rel_ptr  = slot_ptr;
              valid_next        = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Slot state; only the valid bit needs a reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    slot_id  <= slot_id_next;
    slot_ptr <= slot_ptr_next;
    slot_cnt <= slot_cnt_next;
  end

  // Hand the packet to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_out <= '0;
    end else begin
      pkt_out <= pkt_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/reference_count_table.sv
// Top level of the reference count table: input and output stream ports,
// id allocation and the row of slot cells.
// Depends on rct_pkg and rct_cell.
// Usage:
//   The input channel carries one command per transaction: the command code in
//   s_tuser, the pointer and the entry id in s_tdata. Register stores a pointer
//   with count 1 and returns a fresh id (ids run from 1 and wrap back to 1);
//   increment and decrement act on the entry with the given id, and a
//   decrement to zero frees the slot and returns its pointer.
//   The output channel carries exactly one result per command: status and the
//   release flag in m_tuser, the assigned id, the count and the released
//   pointer in m_tdata.
//   A command walks the row of ENTRIES cells, one cell per cycle, and the
//   lowest-numbered cell that can serve it does so. The accepted command is
//   registered into the entry register and then by each cell in turn, and its
//   result into the output register. One command is in the row at a time; the
//   next is taken the cycle after the result reaches the output register.
//   If the receiver stalls, a finished result waits in a skid register behind
//   the output register and no new command is taken until it moves on.
//   Reset empties every slot and sets the next id to 1.
`default_nettype none

module reference_count_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata: pointer_value[31:0], entry_id[47:32]
  input  wire logic [47:0] s_tdata,
  // s_tuser: cmd[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata: assigned_id[15:0], count_after[31:16], released_pointer[63:32]
  output logic [63:0]      m_tdata,
  // m_tuser: status[1:0], released[2]
  output logic [2:0]       m_tuser
);

  localparam int N = rct_pkg::ENTRIES;

  rct_pkg::rct_pkt_t           link [N+1];
  logic [N:0]                  link_active;
  rct_pkg::rct_pkt_t           tail;
  rct_pkg::rct_res_t           res;
  rct_pkg::rct_res_t           out_res;
  rct_pkg::rct_res_t           skid_res;
  logic                        skid_valid;
  logic                        busy;
  logic                        s_accept;
  logic                        out_free;
  logic [rct_pkg::ID_BITS-1:0] next_id;
  rct_pkg::rct_pkt_t           head;
  rct_pkg::rct_pkt_t           entry_pkt;

  assign s_tready = !busy;
  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Build the entry packet for an accepted command.
  always_comb begin
    head          = '0;
    head.active   = s_accept;
    head.cmd      = s_tuser;
    head.ptr      = s_tdata[31:0];
    head.eid      = s_tdata[47:32];
    head.nid      = next_id;
    head.status   = rct_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_pkt <= '0;
    end else begin
      entry_pkt <= head;
    end
  end

  assign link[0] = entry_pkt;

  // The row of slot cells.
  for (genvar i = 0; i < N; i++) begin : g_cell
    rct_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .pkt_in  (link[i]),
      .pkt_out (link[i+1])
    );
  end

  for (genvar i = 0; i <= N; i++) begin : g_act
    assign link_active[i] = link[i].active;
  end

  assign tail = link[N];

  // A command that no cell served ends as full, not found, or an ignored code.
  always_comb begin
    res.assigned = tail.assigned;
    res.count    = tail.count;
    res.released = tail.released;
    res.rel_ptr  = tail.rel_ptr;
    if (tail.hit) begin
      res.status = tail.status;
    end else begin
      case (tail.cmd)
        rct_pkg::CMD_REGISTER:  res.status = rct_pkg::ST_FULL;
        rct_pkg::CMD_INCREMENT: res.status = rct_pkg::ST_NOT_FOUND;
        rct_pkg::CMD_DECREMENT: res.status = rct_pkg::ST_NOT_FOUND;
        default:                res.status = rct_pkg::ST_OK;
      endcase
    end
  end

  // Output register with a skid stage, busy flag and id allocation.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
      busy       <= 1'b0;
      next_id    <= rct_pkg::ID_ONE;
    end else begin
      if (s_accept) begin
        busy <= 1'b1;
      end
      if (out_free) begin
        if (skid_valid) begin
          out_res    <= skid_res;
          m_tvalid   <= 1'b1;
          skid_valid <= 1'b0;
          busy       <= 1'b0;
        end else if (tail.active) begin
          out_res  <= res;
          m_tvalid <= 1'b1;
          busy     <= 1'b0;
        end else begin
          m_tvalid <= 1'b0;
        end
      end else if (tail.active) begin
        skid_res   <= res;
        skid_valid <= 1'b1;
      end
      if (tail.active && tail.hit && (tail.cmd == rct_pkg::CMD_REGISTER)) begin
        next_id <= (next_id == rct_pkg::ID_MAX) ? rct_pkg::ID_ONE
                                                : next_id + rct_pkg::ID_ONE;
      end
    end
  end

  assign m_tdata = {out_res.rel_ptr, out_res.count, out_res.assigned};
  assign m_tuser = {out_res.released, out_res.status};

`ifndef SYNTHESIS
  // Only one command is ever in the row of cells.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    $countones(link_active) <= 1)
    else $error("more than one command in the cell row");

  // No new command is taken while one is being worked on.
  a_no_accept_in_flight: assert property (@(posedge clk) disable iff (rst)
    (link_active != '0) |-> !s_tready)
    else $error("input ready while a command is in the cell row");

  // A successful register moves the next id on.
  a_id_advance: assert property (@(posedge clk) disable iff (rst)
    (tail.active && tail.hit && (tail.cmd == rct_pkg::CMD_REGISTER))
      |=> (next_id != $past(next_id)))
    else $error("next id did not advance after a register");

  // A finished result never lands while the skid stage is still full.
  a_skid_free: assert property (@(posedge clk) disable iff (rst)
    tail.active |-> !skid_valid)
    else $error("result arrived with the skid stage occupied");
`endif

endmodule

`default_nettype wire

>>> test/tb_reference_count_table.sv
// Self-checking testbench for reference_count_table: register, increment and
// decrement commands are streamed in and every result is compared with a model.
// Depends on rct_pkg and the reference_count_table RTL.
`timescale 1ns / 1ps

module tb_reference_count_table;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 480;

  // One command as the testbench keeps it before it is driven.
  typedef struct packed {
    logic [1:0]                   op;
    logic [rct_pkg::PTR_BITS-1:0] addr;
    logic [rct_pkg::ID_BITS-1:0]  key;
  } cmd_item_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;

  reference_count_table uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Model of the table contents, updated as each command is accepted.
  logic                           held_live [rct_pkg::ENTRIES];
  logic [rct_pkg::ID_BITS-1:0]    held_id   [rct_pkg::ENTRIES];
  logic [rct_pkg::PTR_BITS-1:0]   held_ptr  [rct_pkg::ENTRIES];
  logic [rct_pkg::COUNT_BITS-1:0] held_refs [rct_pkg::ENTRIES];
  logic [rct_pkg::ID_BITS-1:0]    id_counter;

  cmd_item_t          cmd_backlog[$];
  rct_pkg::rct_res_t  pending_outcomes[$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  front_sent = 1'b0;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  int  results_seen = 0;
  int  status_tally [4];
  int  release_tally = 0;

  cmd_item_t          accepted_cmd;
  rct_pkg::rct_res_t  got_res;
  rct_pkg::rct_res_t  want_res;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Computes the result of one command and applies it to the model table.
  function automatic rct_pkg::rct_res_t apply_command(cmd_item_t c);
    rct_pkg::rct_res_t r;
    int                hit;
    r = '0;
    r.status = rct_pkg::ST_OK;
    hit = -1;
    case (c.op)
      rct_pkg::CMD_REGISTER: begin
        for (int i = 0; i < rct_pkg::ENTRIES; i++)
          if (hit < 0 && !held_live[i]) hit = i;
        if (hit < 0) begin
          r.status = rct_pkg::ST_FULL;
        end else begin
          held_live[hit] = 1'b1;
          held_id[hit]   = id_counter;
          held_ptr[hit]  = c.addr;
          held_refs[hit] = rct_pkg::COUNT_ONE;
          r.assigned     = id_counter;
          r.count        = rct_pkg::COUNT_ONE;
          id_counter     = (id_counter == rct_pkg::ID_MAX) ? rct_pkg::ID_ONE
                                                           : id_counter + rct_pkg::ID_ONE;
        end
      end
      rct_pkg::CMD_INCREMENT, rct_pkg::CMD_DECREMENT: begin
        // Lookups take the lowest-numbered live slot holding the id.
        for (int i = 0; i < rct_pkg::ENTRIES; i++)
          if (hit < 0 && held_live[i] && held_id[i] == c.key) hit = i;
        if (hit < 0) begin
          r.status = rct_pkg::ST_NOT_FOUND;
        end else if (c.op == rct_pkg::CMD_INCREMENT) begin
          if (held_refs[hit] == rct_pkg::COUNT_MAX) r.status = rct_pkg::ST_SATURATED;
          else held_refs[hit] = held_refs[hit] + rct_pkg::COUNT_ONE;
          r.count = held_refs[hit];
        end else begin
          if (held_refs[hit] != '0) held_refs[hit] = held_refs[hit] - rct_pkg::COUNT_ONE;
          r.count = held_refs[hit];
          if (held_refs[hit] == '0) begin
            r.released    = 1'b1;
            r.rel_ptr     = held_ptr[hit];
            held_live[hit] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Builds a command from the current table: mostly ids that are live, some
  // stale, zero, all-ones or arbitrary ids. Registers thin out as the table fills.
  function automatic cmd_item_t random_command();
    cmd_item_t c;
    int        live_idx[$];
    int        fill;
    int        reg_pct;
    int        roll;
    for (int i = 0; i < rct_pkg::ENTRIES; i++)
      if (held_live[i]) live_idx.push_back(i);
    fill = live_idx.size();
    reg_pct = (fill < 4) ? 60 : ((fill > 13) ? 20 : 35);
    roll = $urandom_range(99);
    if (roll < reg_pct) c.op = rct_pkg::CMD_REGISTER;
    else if (roll < reg_pct + (100 - reg_pct) * 2 / 5) c.op = rct_pkg::CMD_INCREMENT;
    else c.op = rct_pkg::CMD_DECREMENT;
    case ($urandom_range(9))
      0: c.addr = '0;
      1: c.addr = '1;
      default: c.addr = rct_pkg::PTR_BITS'($urandom);
    endcase
    if (fill > 0 && $urandom_range(99) < 75) begin
      c.key = held_id[live_idx[$urandom_range(fill - 1)]];
    end else begin
      case ($urandom_range(5))
        0: c.key = '0;
        1: c.key = '1;
        2, 3: c.key = id_counter - rct_pkg::ID_BITS'($urandom_range(1, 40));
        default: c.key = rct_pkg::ID_BITS'($urandom);
      endcase
    end
    return c;
  endfunction

  function automatic void queue_cmd(logic [1:0] op, logic [rct_pkg::PTR_BITS-1:0] addr,
                                    logic [rct_pkg::ID_BITS-1:0] key);
    cmd_item_t c;
    c.op = op;
    c.addr = addr;
    c.key = key;
    cmd_backlog.push_back(c);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Waits until every queued command has been sent and answered.
  task automatic drain();
    while (cmd_backlog.size() != 0 || pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(input int count, input int idle_s, input int stall_r);
    send_idle_pct = idle_s;
    recv_stall_pct = stall_r;
    for (int k = 0; k < count; k++) begin
      while (cmd_backlog.size() != 0) @(posedge clk);
      cmd_backlog.push_back(random_command());
    end
    drain();
  endtask

  // Driver: presents the front command, holding it until the transaction completes.
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || front_sent) begin
        front_sent = 1'b0;
        if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {cmd_backlog[0].key, cmd_backlog[0].addr};
          s_tuser  <= cmd_backlog[0].op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on each input transaction, checks each output transaction.
  always @(posedge clk) begin
    if (!rst) begin
      quiet_cycles++;
      if (s_tvalid && s_tready) begin
        accepted_cmd = cmd_backlog.pop_front();
        pending_outcomes.push_back(apply_command(accepted_cmd));
        front_sent = 1'b1;
        quiet_cycles = 0;
      end
      if (m_tvalid && m_tready) begin
        quiet_cycles = 0;
        got_res.status   = m_tuser[1:0];
        got_res.released = m_tuser[2];
        got_res.assigned = m_tdata[15:0];
        got_res.count    = m_tdata[31:16];
        got_res.rel_ptr  = m_tdata[63:32];
        if (pending_outcomes.size() == 0) begin
          $error("result with no command outstanding: m_tdata 0x%0h m_tuser 0x%0h",
                 m_tdata, m_tuser);
          mismatches++;
        end else begin
          want_res = pending_outcomes.pop_front();
          check_field("status", want_res.status, got_res.status);
          check_field("assigned_id", want_res.assigned, got_res.assigned);
          check_field("count_after", want_res.count, got_res.count);
          check_field("released", want_res.released, got_res.released);
          check_field("released_pointer", want_res.rel_ptr, got_res.rel_ptr);
          results_seen++;
          status_tally[got_res.status]++;
          if (got_res.released) release_tally++;
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    for (int i = 0; i < rct_pkg::ENTRIES; i++) begin
      held_live[i] = 1'b0;
      held_id[i]   = '0;
      held_ptr[i]  = '0;
      held_refs[i] = '0;
    end
    id_counter = rct_pkg::ID_ONE;
    for (int i = 0; i < 4; i++) status_tally[i] = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: unknown ids on an empty table, fill to full, a register on a
    // full table, count up and down to release, then reuse of the lowest slot.
    queue_cmd(rct_pkg::CMD_DECREMENT, '0, '0);
    queue_cmd(rct_pkg::CMD_INCREMENT, '1, '1);
    queue_cmd(rct_pkg::CMD_REGISTER, '0, '0);
    queue_cmd(rct_pkg::CMD_REGISTER, '1, '1);
    for (int i = 2; i < rct_pkg::ENTRIES; i++)
      queue_cmd(rct_pkg::CMD_REGISTER, rct_pkg::PTR_BITS'($urandom), '0);
    queue_cmd(rct_pkg::CMD_REGISTER, 32'h1234_5678, '0);
    queue_cmd(rct_pkg::CMD_INCREMENT, '0, rct_pkg::ID_BITS'(1));
    queue_cmd(rct_pkg::CMD_DECREMENT, '0, rct_pkg::ID_BITS'(1));
    queue_cmd(rct_pkg::CMD_DECREMENT, '0, rct_pkg::ID_BITS'(1));
    queue_cmd(rct_pkg::CMD_DECREMENT, '0, rct_pkg::ID_BITS'(1));
    queue_cmd(rct_pkg::CMD_REGISTER, 32'hA5A5_5A5A, '0);
    queue_cmd(rct_pkg::CMD_DECREMENT, '1, rct_pkg::ID_BITS'(2));
    drain();

    // Random traffic under each flow-control pattern.
    run_random(RANDOM_PER_PHASE, 0, 0);
    run_random(RANDOM_PER_PHASE, 79, 0);
    run_random(RANDOM_PER_PHASE, 0, 79);
    run_random(RANDOM_PER_PHASE, 21, 21);

    repeat (4 * rct_pkg::ENTRIES) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      $error("%0d results never arrived", pending_outcomes.size());
      mismatches++;
    end

    $display("Checked %0d results: %0d ok, %0d full, %0d not found, %0d saturated.",
             results_seen, status_tally[rct_pkg::ST_OK], status_tally[rct_pkg::ST_FULL],
             status_tally[rct_pkg::ST_NOT_FOUND], status_tally[rct_pkg::ST_SATURATED]);
    $display("%0d entries released; next id to be handed out is %0d.",
             release_tally, id_counter);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rct_pkg.sv
rtl/rct_cell.sv
rtl/reference_count_table.sv
test/tb_reference_count_table.sv
